FILE: sv/atad_pkg.sv
// shared types and constants of the adc throttle averaging block
// no dependencies; imported by every other file of the block
package atad_pkg;

    localparam int SAMPLE_W = 12;
    localparam int AVG_W    = 12;
    localparam int THR_W    = 16;
    localparam int MID_W    = 12;
    localparam int FULL_W   = 12;
    localparam int DB_W     = 11;
    localparam int LIMIT_W  = 15;
    localparam int ADDR_W   = 4;
    localparam int DATA_W   = 32;

    localparam int MIDPOINT = 2048;
    localparam logic [SAMPLE_W-1:0] MID_CODE = 12'd2048;

    localparam logic [MID_W-1:0]   MID_RST   = 12'd2048;
    localparam logic [FULL_W-1:0]  FULL_RST  = 12'd4095;
    localparam logic [DB_W-1:0]    DB_RST    = 11'd64;
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd1000;

    localparam logic [1:0] REG_MID   = 2'd0;
    localparam logic [1:0] REG_FULL  = 2'd1;
    localparam logic [1:0] REG_DB    = 2'd2;
    localparam logic [1:0] REG_LIMIT = 2'd3;

    localparam int THR_Q = 15;
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] THR_LAST = 4'd14;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_AVG,
        ST_SHAPE,
        ST_MUL,
        ST_DIV_THR,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [MID_W-1:0]   mid_level;
        logic [FULL_W-1:0]  full_scale;
        logic [DB_W-1:0]    dead_band;
        logic [LIMIT_W-1:0] throttle_limit;
    } t_cfg;

    typedef struct packed {
        logic take;
        logic read;
        logic update;
        logic avg;
        logic div_step;
        logic shape;
        logic mul;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

FILE: sv/atad_in_if.sv
// input channel of the block: channel number and raw sample per item
// depends on atad_pkg
interface atad_in_if;
    import atad_pkg::*;

    logic                valid;
    logic                ready;
    logic                channel;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink   (input valid, input channel, input sample, output ready);
endinterface

FILE: sv/atad_out_if.sv
// output channel of the block: average and signed throttle per item
// depends on atad_pkg
interface atad_out_if;
    import atad_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [AVG_W-1:0]        average;
    logic signed [THR_W-1:0] throttle;

    modport source (output valid, output average, output throttle, input ready);
    modport sink   (input valid, input average, input throttle, output ready);
endinterface

FILE: sv/atad_cfg.sv
// apb register file holding mid level, full scale, dead band and limit
// depends on atad_pkg
module atad_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [atad_pkg::ADDR_W-1:0]  paddr,
    input  logic [atad_pkg::DATA_W-1:0]  pwdata,
    output logic [atad_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output atad_pkg::t_cfg               o_cfg
);
    import atad_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mid_level      <= MID_RST;
            r_cfg.full_scale     <= FULL_RST;
            r_cfg.dead_band      <= DB_RST;
            r_cfg.throttle_limit <= LIMIT_RST;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_MID:   r_cfg.mid_level      <= pwdata[MID_W-1:0];
                REG_FULL:  r_cfg.full_scale     <= pwdata[FULL_W-1:0];
                REG_DB:    r_cfg.dead_band      <= pwdata[DB_W-1:0];
                REG_LIMIT: r_cfg.throttle_limit <= pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_MID:   prdata = DATA_W'(r_cfg.mid_level);
            REG_FULL:  prdata = DATA_W'(r_cfg.full_scale);
            REG_DB:    prdata = DATA_W'(r_cfg.dead_band);
            REG_LIMIT: prdata = DATA_W'(r_cfg.throttle_limit);
            default:   prdata = '0;
        endcase
    end
endmodule

FILE: sv/atad_ctrl.sv
// sequencer: ring read and update, average division, shaping, scale division
// depends on atad_pkg; drives the datapath through t_cmd
module atad_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  atad_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output atad_pkg::t_cmd  o_cmd
);
    import atad_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = ST_READ;
                end
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_UPDATE;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = ST_AVG;
            end
            ST_AVG: begin
                o_cmd.avg = 1'b1;
                n_state   = ST_SHAPE;
            end
            ST_SHAPE: begin
                o_cmd.shape = 1'b1;
                n_state     = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_DIV_THR;
            end
            ST_DIV_THR: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == THR_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_FINISH;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_cnt   = '0;
            end
        endcase
    end
endmodule

FILE: sv/atad_dp.sv
// datapath: sample ring memory, running sums, reciprocal average, restoring
// scale divider, dead zone and scaling, output register; depends on atad_pkg
module atad_dp #(
    parameter int WINDOW   = 256,
    parameter int CHANNELS = 2
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  atad_pkg::t_cmd                      i_cmd,
    input  atad_pkg::t_cfg                      i_cfg,
    input  logic                                i_channel,
    input  logic [atad_pkg::SAMPLE_W-1:0]       i_sample,
    input  logic                                i_out_ready,
    output atad_pkg::t_stat                     o_stat,
    output logic                                o_out_valid,
    output logic [atad_pkg::AVG_W-1:0]          o_average,
    output logic signed [atad_pkg::THR_W-1:0]   o_throttle
);
    import atad_pkg::*;

    localparam int SLW   = $clog2(WINDOW);
    localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * WINDOW;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = SAMPLE_W + SLW;
    localparam int RK    = SW + SLW;
    localparam int RW    = SW + 1;
    localparam logic [SW-1:0]  SUM_RST   = SW'(MIDPOINT * WINDOW);
    localparam logic [SLW-1:0] SLOT_LAST = SLW'(WINDOW - 1);
    localparam logic [RW-1:0]  RECIP     =
        RW'(((64'd1 << RK) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    logic [CIW-1:0]      r_ch;
    logic [SAMPLE_W-1:0] r_smp;
    logic [SW-1:0]       r_sum  [CHANNELS];
    logic [SLW-1:0]      r_slot [CHANNELS];
    logic                r_fill [CHANNELS];
    logic [SW-1:0]       r_cur_sum;
    logic [SLW-1:0]      r_cur_slot;
    logic                r_cur_fill;
    logic [AW-1:0]       r_addr;
    logic [SAMPLE_W-1:0] r_rd;
    logic [SAMPLE_W-1:0] mem [DEPTH];

    logic [11:0]         r_rem;
    logic [THR_Q-1:0]    r_dq;
    logic [AVG_W-1:0]    r_avg;
    logic                r_neg, r_zero, r_big;
    logic [11:0]         r_mag2;
    logic signed [14:0]  r_span;

    logic                    r_out_valid;
    logic [AVG_W-1:0]        r_avg_out;
    logic signed [THR_W-1:0] r_thr_out;

    logic [CIW-1:0]      ch_in;
    logic [AW-1:0]       addr;
    logic [SAMPLE_W-1:0] old_smp;
    logic [SW-1:0]       new_sum;
    logic [SLW-1:0]      next_slot;
    logic [SW+RW-1:0]    avg_prod;
    logic [11:0]         divisor;
    logic [12:0]         trial, diff;
    logic                ge;
    logic [12:0]         offset;
    logic [11:0]         mag, half;
    logic [12:0]         tri_db;
    logic [14:0]         span_w;
    logic [26:0]         prod;
    logic                span_pos;
    logic [LIMIT_W-1:0]  res;

    assign ch_in     = (CHANNELS > 1) ? CIW'(i_channel) : '0;
    assign addr      = AW'(AW'(r_ch) * AW'(WINDOW)) + AW'(r_slot[r_ch]);
    assign old_smp   = r_cur_fill ? r_rd : MID_CODE;
    assign new_sum   = r_cur_sum - SW'(old_smp) + SW'(r_smp);
    assign next_slot = (r_cur_slot == SLOT_LAST) ? '0 : r_cur_slot + 1'b1;

    // sum / WINDOW by multiplying with the rounded-up reciprocal
    assign avg_prod = {{RW{1'b0}}, r_cur_sum} * {{SW{1'b0}}, RECIP};

    assign divisor = r_span[11:0];
    assign trial   = {r_rem, r_dq[THR_Q-1]};
    assign ge      = trial >= {1'b0, divisor};
    assign diff    = trial - {1'b0, divisor};

    assign offset  = {1'b0, r_dq[AVG_W-1:0]} - {1'b0, i_cfg.mid_level};
    assign mag     = offset[12] ? 12'(-offset) : offset[11:0];
    assign half    = {2'b00, i_cfg.dead_band[DB_W-1:1]};
    assign tri_db  = {2'b00, i_cfg.dead_band} + {1'b0, i_cfg.dead_band, 1'b0};
    assign span_w  = {3'b000, i_cfg.full_scale} - {3'b000, i_cfg.mid_level}
                     - {3'b000, tri_db[12:1]};

    assign prod     = {15'd0, r_mag2} * {12'd0, i_cfg.throttle_limit};
    assign span_pos = !r_span[14] && (r_span != '0);

    always_comb begin
        if (r_zero) begin
            res = '0;
        end else if (!span_pos) begin
            res = (r_mag2 == '0) ? '0 : i_cfg.throttle_limit;
        end else if (r_big) begin
            res = i_cfg.throttle_limit;
        end else begin
            res = r_dq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                r_sum[c]  <= SUM_RST;
                r_slot[c] <= '0;
                r_fill[c] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_sum[r_ch]  <= new_sum;
                r_slot[r_ch] <= next_slot;
                if (r_cur_slot == SLOT_LAST) begin
                    r_fill[r_ch] <= 1'b1;
                end
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd <= mem[addr];
        end
        if (i_cmd.update) begin
            mem[r_addr] <= r_smp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_ch  <= ch_in;
            r_smp <= i_sample;
        end
        if (i_cmd.read) begin
            r_addr     <= addr;
            r_cur_sum  <= r_sum[r_ch];
            r_cur_slot <= r_slot[r_ch];
            r_cur_fill <= r_fill[r_ch];
        end else if (i_cmd.update) begin
            r_cur_sum <= new_sum;
        end
        if (i_cmd.avg) begin
            r_dq <= THR_Q'(avg_prod[RK +: AVG_W]);
        end else if (i_cmd.div_step) begin
            r_rem <= ge ? diff[11:0] : trial[11:0];
            r_dq  <= {r_dq[THR_Q-2:0], ge};
        end else if (i_cmd.mul) begin
            r_rem <= prod[26:THR_Q];
            r_dq  <= prod[THR_Q-1:0];
        end
        if (i_cmd.shape) begin
            r_avg  <= r_dq[AVG_W-1:0];
            r_neg  <= offset[12];
            r_zero <= mag < half;
            r_mag2 <= mag - half;
            r_span <= span_w;
        end
        if (i_cmd.mul) begin
            r_big <= {3'b000, r_mag2} > $unsigned(r_span);
        end
        if (i_cmd.finish) begin
            r_avg_out <= r_avg;
            r_thr_out <= r_neg ? -$signed({1'b0, res}) : $signed({1'b0, res});
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_average       = r_avg_out;
    assign o_throttle      = r_thr_out;
endmodule

FILE: sv/adc_throttle_average_deadzone_top.sv
// top level of the adc throttle averaging block; one item at a time: an item
// passes ring read and update, reciprocal average, shaping, multiply and the
// 15-step scale division before the next one is accepted
// the output register lets the next item start while a result waits
// synchronous active-low reset; ring entries read as midpoint until first written
module adc_throttle_average_deadzone_top #(
    parameter int WINDOW   = 256,
    parameter int CHANNELS = 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    atad_in_if.sink                      i_in,
    atad_out_if.source                   o_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [atad_pkg::ADDR_W-1:0]  paddr,
    input  logic [atad_pkg::DATA_W-1:0]  pwdata,
    output logic [atad_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import atad_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    atad_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    atad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_stat     (stat),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    atad_dp #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_channel   (i_in.channel),
        .i_sample    (i_in.sample),
        .i_out_ready (o_out.ready),
        .o_stat      (stat),
        .o_out_valid (o_out.valid),
        .o_average   (o_out.average),
        .o_throttle  (o_out.throttle)
    );
endmodule

FILE: sv/atad_checker.sv
// port-level checks of the adc throttle averaging block and their bind
// depends on atad_pkg and adc_throttle_average_deadzone_top
module atad_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [atad_pkg::AVG_W-1:0]        i_average,
    input logic signed [atad_pkg::THR_W-1:0] i_throttle
);
    import atad_pkg::*;

    logic in_acc;
    assign in_acc = i_in_valid && i_in_ready;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("input ready right after an accepted item");

    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !$rose(i_out_valid))
        else $error("result appeared one cycle after accept");

    a_throttle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_throttle != {1'b1, {(THR_W-1){1'b0}}})
        else $error("throttle outside symmetric range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_average)
            && $stable(i_throttle))
        else $error("stalled result changed");
endmodule

bind adc_throttle_average_deadzone_top atad_checker u_atad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_average   (o_out.average),
    .i_throttle  (o_out.throttle)
);

FILE: bench/atad_check.sv
`timescale 1ns / 1ps
// result checker for the adc throttle averaging block: watches both item channels
// and the register port, predicts each result and compares it; needs atad_pkg and the interfaces
module atad_check #(
    parameter int WINDOW   = 256,
    parameter int CHANNELS = 2
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    atad_in_if                          i_in_mon,
    atad_out_if                         i_out_mon,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [atad_pkg::ADDR_W-1:0] i_paddr,
    input  logic [atad_pkg::DATA_W-1:0] i_pwdata,
    input  logic [atad_pkg::DATA_W-1:0] i_prdata,
    input  logic                        i_pready,
    output int                          o_fail_count,
    output int                          o_pending
);
    import atad_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_W + SLOT_W;

    typedef struct packed {
        logic [AVG_W-1:0]        average;
        logic signed [THR_W-1:0] throttle;
    } t_reading;

    logic [SAMPLE_W-1:0] level_ring [CHANNELS][WINDOW];
    logic [SUM_W-1:0]    level_sum  [CHANNELS];
    logic [SLOT_W-1:0]   next_slot  [CHANNELS];
    t_cfg                cfg;
    t_reading            readings_due[$];
    int                  mismatches = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = readings_due.size();

    function automatic logic signed [THR_W-1:0] shape_throttle(logic [AVG_W-1:0] avg);
        int     offset;
        int     mag;
        int     half;
        int     span;
        int     limit;
        int     res;
        longint q;
        offset = int'(avg) - int'(cfg.mid_level);
        mag    = (offset < 0) ? -offset : offset;
        half   = int'(cfg.dead_band) / 2;
        span   = int'(cfg.full_scale) - int'(cfg.mid_level) - (int'(cfg.dead_band) * 3) / 2;
        limit  = int'(cfg.throttle_limit);
        if (mag < half) begin
            return '0;
        end
        mag = mag - half;
        if (span <= 0) begin
            res = (mag == 0) ? 0 : limit;
        end else if (mag > span) begin
            res = limit;
        end else begin
            q   = (longint'(mag) * longint'(limit)) / longint'(span);
            res = (q > limit) ? limit : int'(q);
        end
        return THR_W'((offset < 0) ? -res : res);
    endfunction

    function automatic t_reading absorb_sample(logic ch, logic [SAMPLE_W-1:0] smp);
        int       c;
        t_reading r;
        c = int'(ch) % CHANNELS;
        level_sum[c] = level_sum[c] - SUM_W'(level_ring[c][next_slot[c]]) + SUM_W'(smp);
        level_ring[c][next_slot[c]] = smp;
        next_slot[c] = SLOT_W'((int'(next_slot[c]) + 1) % WINDOW);
        r.average  = AVG_W'(level_sum[c] / WINDOW);
        r.throttle = shape_throttle(r.average);
        return r;
    endfunction

    function automatic logic [DATA_W-1:0] register_value(logic [1:0] idx);
        case (idx)
            REG_MID:   return DATA_W'(cfg.mid_level);
            REG_FULL:  return DATA_W'(cfg.full_scale);
            REG_DB:    return DATA_W'(cfg.dead_band);
            REG_LIMIT: return DATA_W'(cfg.throttle_limit);
            default:   return '0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_reading   want;
        logic [1:0] idx;
        idx = i_paddr[ADDR_W-1:2];
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNELS; c++) begin
                for (int s = 0; s < WINDOW; s++) begin
                    level_ring[c][s] = MID_CODE;
                end
                level_sum[c] = SUM_W'(MIDPOINT * WINDOW);
                next_slot[c] = '0;
            end
            cfg = '{mid_level: MID_RST, full_scale: FULL_RST, dead_band: DB_RST,
                    throttle_limit: LIMIT_RST};
            readings_due.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (readings_due.size() == 0) begin
                    mismatches++;
                    $error("result with no item pending: average %0d throttle %0d",
                           i_out_mon.average, i_out_mon.throttle);
                end else begin
                    want = readings_due.pop_front();
                    if (i_out_mon.average !== want.average) begin
                        mismatches++;
                        $error("average mismatch: expected %0d, got %0d",
                               want.average, i_out_mon.average);
                    end
                    if (i_out_mon.throttle !== want.throttle) begin
                        mismatches++;
                        $error("throttle mismatch: expected %0d, got %0d",
                               want.throttle, i_out_mon.throttle);
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                readings_due.push_back(absorb_sample(i_in_mon.channel, i_in_mon.sample));
            end
            if (i_psel && i_penable && i_pready) begin
                if (i_pwrite) begin
                    case (idx)
                        REG_MID:   cfg.mid_level      = i_pwdata[MID_W-1:0];
                        REG_FULL:  cfg.full_scale     = i_pwdata[FULL_W-1:0];
                        REG_DB:    cfg.dead_band      = i_pwdata[DB_W-1:0];
                        REG_LIMIT: cfg.throttle_limit = i_pwdata[LIMIT_W-1:0];
                        default: ;
                    endcase
                end else if (i_prdata !== register_value(idx)) begin
                    mismatches++;
                    $error("prdata mismatch at register %0d: expected %0d, got %0d",
                           idx, register_value(idx), i_prdata);
                end
            end
        end
    end

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// top of the adc throttle averaging bench: clock, reset, register setup, item stimulus
// with random gaps and output stalls; checking lives in atad_check, needs atad_pkg
module tb;
    import atad_pkg::*;

    localparam int WINDOW        = 256;
    localparam int CHANNELS      = 2;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 40;
    localparam int FIXED_SETTINGS = 5;
    localparam int RANDOM_SETTINGS = 3;

    localparam int FIXED_MID   [FIXED_SETTINGS] = '{2048, 0, 4095, 3000, 2000};
    localparam int FIXED_FULL  [FIXED_SETTINGS] = '{4095, 4095, 1, 3000, 2300};
    localparam int FIXED_DB    [FIXED_SETTINGS] = '{0, 1024, 2047, 0, 100};
    localparam int FIXED_LIMIT [FIXED_SETTINGS] = '{32767, 1, 32767, 0, 32767};

    localparam int DIRECTED_ITEMS = 16;
    localparam logic DIR_CH [DIRECTED_ITEMS] = '{0, 1, 0, 1, 0, 1, 0, 1,
                                                0, 1, 0, 1, 0, 1, 0, 1};
    localparam logic [SAMPLE_W-1:0] DIR_SAMPLE [DIRECTED_ITEMS] = '{
        12'd0, 12'd4095, 12'd4095, 12'd0, 12'd2048, 12'd2048, 12'hAAA, 12'h555,
        12'h555, 12'hAAA, 12'd1, 12'd4094, 12'd2047, 12'd2049, 12'h800, 12'h7FF};

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int fail_count;
    int pending_count;
    int burst_left = 0;
    int cycles     = 0;

    atad_in_if  in_ch ();
    atad_out_if out_ch ();

    adc_throttle_average_deadzone_top #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    atad_check #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_prdata     (prdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // output side stalls on its own pattern, with long open stretches now and then
    initial begin
        int open_len;
        int stall_len;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            open_len  = ($urandom_range(0, 7) == 0) ? $urandom_range(200, 600)
                                                    : $urandom_range(1, 40);
            stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            out_ch.ready <= 1'b1;
            repeat (open_len) @(negedge i_clk);
            if (stall_len > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall_len) @(negedge i_clk);
            end
        end
    end

    task automatic apb_access(logic [1:0] idx, logic wr, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_register(logic [1:0] idx, int value, int width);
        logic [DATA_W-1:0] data;
        // junk above the register width must be dropped by the block
        data = ($urandom << width) | DATA_W'(value);
        apb_access(idx, 1'b1, data);
    endtask

    task automatic read_back_all();
        apb_access(REG_MID, 1'b0, '0);
        apb_access(REG_FULL, 1'b0, '0);
        apb_access(REG_DB, 1'b0, '0);
        apb_access(REG_LIMIT, 1'b0, '0);
    endtask

    task automatic load_setting(int mid, int full, int db, int limit);
        set_register(REG_MID, mid, MID_W);
        set_register(REG_FULL, full, FULL_W);
        set_register(REG_DB, db, DB_W);
        set_register(REG_LIMIT, limit, LIMIT_W);
        read_back_all();
    endtask

    // sender works in bursts; a new burst may start after a gap
    task automatic send_item(logic ch, logic [SAMPLE_W-1:0] smp);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        in_ch.valid   <= 1'b1;
        in_ch.channel <= ch;
        in_ch.sample  <= smp;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    // segments hold a level on one or both channels so the averages travel far
    task automatic run_random(int count);
        int   seg_left;
        int   target;
        int   amp;
        int   chan_mode;
        int   s;
        logic ch;
        seg_left = 0;
        repeat (count) begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 150);
                case ($urandom_range(0, 3))
                    0:       target = 0;
                    1:       target = 4095;
                    default: target = $urandom_range(0, 4095);
                endcase
                amp = ($urandom_range(0, 3) == 0) ? 4095 : $urandom_range(0, 64);
                chan_mode = $urandom_range(0, 2);
            end
            seg_left--;
            ch = (chan_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(chan_mode);
            s  = target + int'($urandom_range(0, 2 * amp)) - amp;
            if (s < 0) s = 0;
            if (s > 4095) s = 4095;
            send_item(ch, SAMPLE_W'(s));
        end
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_ch.valid   = 1'b0;
        in_ch.channel = 1'b0;
        in_ch.sample  = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset values of the registers, then directed and random items at reset setting
        read_back_all();
        for (int k = 0; k < DIRECTED_ITEMS; k++) begin
            send_item(DIR_CH[k], DIR_SAMPLE[k]);
        end
        run_random(250);
        drain();

        // fixed settings cover the extremes, non-positive span and zero limit
        for (int p = 0; p < FIXED_SETTINGS; p++) begin
            load_setting(FIXED_MID[p], FIXED_FULL[p], FIXED_DB[p], FIXED_LIMIT[p]);
            run_random(180);
            drain();
        end
        for (int p = 0; p < RANDOM_SETTINGS; p++) begin
            load_setting($urandom_range(0, 4095), $urandom_range(1, 4095),
                         $urandom_range(0, 1024), $urandom_range(1, 32767));
            run_random(180);
            drain();
        end

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
